// ===== rtl/core/sct_pkg.sv =====
// sct_pkg: shared types and fixed widths for the segment crossing test
// holds the item payload structs used on the top-level ports
// no dependencies
package sct_pkg;

    // coordinate and tolerance widths
    localparam int COORD_W = 32;
    localparam int TOL_W   = 16;

    // one input item: two segments, signed fixed-point coordinates
    typedef struct packed {
        logic signed [COORD_W-1:0] seg1_start_x;
        logic signed [COORD_W-1:0] seg1_start_y;
        logic signed [COORD_W-1:0] seg1_end_x;
        logic signed [COORD_W-1:0] seg1_end_y;
        logic signed [COORD_W-1:0] seg2_start_x;
        logic signed [COORD_W-1:0] seg2_start_y;
        logic signed [COORD_W-1:0] seg2_end_x;
        logic signed [COORD_W-1:0] seg2_end_y;
    } seg_pair_t;

    // one result item
    typedef struct packed {
        logic crosses;
        logic saturated;
    } cross_result_t;

endpackage

// ===== rtl/core/sct_div.sv =====
// sct_div: pipelined restoring divider, one quotient bit per stage
// unsigned magnitudes in, signed saturating quotient out, side data carried along
// no dependencies
module sct_div #(
    parameter int NW = 49,
    parameter int DW = 32,
    parameter int QB = 48,
    parameter int PW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NW-1:0]        num_mag,
    input  logic [DW-1:0]        den_mag,
    input  logic                 neg,
    input  logic [PW-1:0]        side_in,
    output logic                 out_valid,
    output logic signed [QB-1:0] quot,
    output logic                 sat,
    output logic [PW-1:0]        side_out
);

    localparam int TW = ((NW - QB) > DW) ? (NW - QB) : DW;
    localparam logic [QB-1:0] QPOS = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] QNEG = {1'b1, {(QB-1){1'b0}}};

    logic          valid_reg [0:QB];
    logic [DW-1:0] rem_reg   [0:QB];
    logic [QB-1:0] ql_reg    [0:QB];
    logic [DW-1:0] den_reg   [0:QB];
    logic          neg_reg   [0:QB];
    logic          ovf_reg   [0:QB];
    logic [PW-1:0] side_reg  [0:QB];

    logic                 out_valid_reg;
    logic signed [QB-1:0] quot_reg;
    logic                 sat_reg;
    logic [PW-1:0]        side_out_reg;

    logic [TW-1:0] top_ext;
    logic [TW-1:0] den_ext;
    logic          ovf_next;

    // quotient would not fit when the upper numerator part reaches the divisor
    assign top_ext  = TW'(num_mag[NW-1:QB]);
    assign den_ext  = TW'(den_mag);
    assign ovf_next = (top_ext >= den_ext);

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DW'(num_mag[NW-1:QB]);
        ql_reg[0]   <= num_mag[QB-1:0];
        den_reg[0]  <= den_mag;
        neg_reg[0]  <= neg;
        ovf_reg[0]  <= ovf_next;
        side_reg[0] <= side_in;
    end

    // one restoring step per stage
    for (genvar i = 1; i <= QB; i++)
    begin : g_step
        logic [DW:0]   shifted;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            shifted  = {rem_reg[i-1], ql_reg[i-1][QB-1]};
            diff     = shifted - {1'b0, den_reg[i-1]};
            ge       = (shifted >= {1'b0, den_reg[i-1]});
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= rem_next;
            ql_reg[i]   <= {ql_reg[i-1][QB-2:0], ge};
            den_reg[i]  <= den_reg[i-1];
            neg_reg[i]  <= neg_reg[i-1];
            ovf_reg[i]  <= ovf_reg[i-1];
            side_reg[i] <= side_reg[i-1];
        end
    end

    // sign and saturation
    logic [QB-1:0]        q_fin;
    logic                 over;
    logic                 sat_next;
    logic signed [QB-1:0] quot_next;

    always_comb
    begin
        q_fin    = ql_reg[QB];
        over     = neg_reg[QB] ? (q_fin[QB-1] & (|q_fin[QB-2:0])) : q_fin[QB-1];
        sat_next = ovf_reg[QB] | over;
        if (sat_next)
        begin
            quot_next = neg_reg[QB] ? $signed(QNEG) : $signed(QPOS);
        end
        else
        begin
            quot_next = neg_reg[QB] ? $signed(-q_fin) : $signed(q_fin);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        sat_reg      <= sat_next;
        side_out_reg <= side_reg[QB];
    end

    assign out_valid = out_valid_reg;
    assign quot      = quot_reg;
    assign sat       = sat_reg;
    assign side_out  = side_out_reg;

endmodule

// ===== rtl/core/segment_crossing_test_top.sv =====
// segment_crossing_test_top: strict 2D segment crossing test, slope-intercept form
// depends on sct_pkg (payload types) and sct_div (pipelined divider)
// throughput: one item per cycle, busy stays low; the slope dividers and the crossing-x divider set the depth
// the receiver cannot stall: each result is shown for one cycle with done high
// reset: pipeline valid bits cleared, tolerance returns to 1
module segment_crossing_test_top #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  sct_pkg::seg_pair_t                   segs,
    output logic                                 busy,
    output logic                                 done,
    output sct_pkg::cross_result_t               result,
    input  logic                                 tolerance_we,
    input  logic [sct_pkg::TOL_W-1:0]            tolerance_data
);

    localparam int CW    = sct_pkg::COORD_W;
    localparam int TLW   = sct_pkg::TOL_W;
    localparam int F     = COORD_FRAC_BITS;
    localparam int W     = CW + F;
    localparam int H     = W / 2;
    localparam int DXW   = CW + 1;
    localparam int NWS   = W + 1;
    localparam int MA_W  = W + DXW;
    localparam int SH_W  = MA_W - F;
    localparam int YV_W  = SH_W + 1;
    localparam int BW    = SH_W + 1;
    localparam int DFW   = BW + 1;
    localparam int NWX   = DFW + F;
    localparam int MF_W  = 2 * W;
    localparam int FS_W  = MF_W - F;
    localparam int YF_W  = FS_W + 1;
    localparam int SEGW  = $bits(sct_pkg::seg_pair_t);
    localparam int PW1   = SEGW + 1;
    localparam int PWX   = W + BW + SEGW + 3;
    localparam logic signed [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

    // open interval test against an unordered pair of bounds
    function automatic logic strictly_between(input logic signed [W-1:0] v,
                                              input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
        strictly_between = ((a < v) && (v < b)) || ((b < v) && (v < a));
    endfunction

    // tolerance register
    logic [TLW-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TLW'(1);
        end
        else if (tolerance_we)
        begin
            tol_reg <= tolerance_data;
        end
    end

    assign busy = 1'b0;

    // stage 1: input register
    logic               s1_valid_reg;
    sct_pkg::seg_pair_t s1_segs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_segs_reg <= segs;
    end

    // stage 2: extents, vertical tests, slope divider operands
    logic signed [DXW-1:0] dx1, dy1, dx2, dy2;
    logic [DXW-1:0]        adx1, ady1, adx2, ady2;
    logic                  v1_next, v2_next;

    always_comb
    begin
        dx1  = DXW'(s1_segs_reg.seg1_end_x) - DXW'(s1_segs_reg.seg1_start_x);
        dy1  = DXW'(s1_segs_reg.seg1_end_y) - DXW'(s1_segs_reg.seg1_start_y);
        dx2  = DXW'(s1_segs_reg.seg2_end_x) - DXW'(s1_segs_reg.seg2_start_x);
        dy2  = DXW'(s1_segs_reg.seg2_end_y) - DXW'(s1_segs_reg.seg2_start_y);
        adx1 = dx1[CW] ? DXW'(-dx1) : DXW'(dx1);
        ady1 = dy1[CW] ? DXW'(-dy1) : DXW'(dy1);
        adx2 = dx2[CW] ? DXW'(-dx2) : DXW'(dx2);
        ady2 = dy2[CW] ? DXW'(-dy2) : DXW'(dy2);
        v1_next = (adx1 == '0) || (adx1 < DXW'(tol_reg));
        v2_next = (adx2 == '0) || (adx2 < DXW'(tol_reg));
    end

    logic               s2_valid_reg;
    sct_pkg::seg_pair_t s2_segs_reg;
    logic [NWS-1:0]     s2_num1_reg, s2_num2_reg;
    logic [CW-1:0]      s2_den1_reg, s2_den2_reg;
    logic               s2_neg1_reg, s2_neg2_reg;
    logic               s2_v1_reg, s2_v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_segs_reg <= s1_segs_reg;
        s2_num1_reg <= {1'b0, ady1[CW-1:0], {F{1'b0}}};
        s2_num2_reg <= {1'b0, ady2[CW-1:0], {F{1'b0}}};
        s2_den1_reg <= adx1[CW-1:0];
        s2_den2_reg <= adx2[CW-1:0];
        s2_neg1_reg <= dy1[CW] ^ dx1[CW];
        s2_neg2_reg <= dy2[CW] ^ dx2[CW];
        s2_v1_reg   <= v1_next;
        s2_v2_reg   <= v2_next;
    end

    // slope dividers, one per segment
    logic                 d1_valid, d2_valid;
    logic signed [W-1:0]  k1, k2;
    logic                 ksat1, ksat2;
    logic [PW1-1:0]       d1_side;
    logic                 d2_side;

    sct_div #(.NW(NWS), .DW(CW), .QB(W), .PW(PW1)) u_div_k1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid_reg),
        .num_mag  (s2_num1_reg),
        .den_mag  (s2_den1_reg),
        .neg      (s2_neg1_reg),
        .side_in  ({s2_v1_reg, s2_segs_reg}),
        .out_valid(d1_valid),
        .quot     (k1),
        .sat      (ksat1),
        .side_out (d1_side)
    );

    sct_div #(.NW(NWS), .DW(CW), .QB(W), .PW(1)) u_div_k2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid_reg),
        .num_mag  (s2_num2_reg),
        .den_mag  (s2_den2_reg),
        .neg      (s2_neg2_reg),
        .side_in  (s2_v2_reg),
        .out_valid(d2_valid),
        .quot     (k2),
        .sat      (ksat2),
        .side_out (d2_side)
    );

    // stage 3: case split, partial products for intercepts or line evaluation
    sct_pkg::seg_pair_t    d_segs;
    logic                  d_v1, d_v2, one1, one2, gen;
    logic signed [W-1:0]   ksel;
    logic signed [DXW-1:0] tsel;
    logic signed [DXW-1:0] x2a_ext;
    logic signed [CW-1:0]  yb_next;
    logic                  sat3_next;

    always_comb
    begin
        d_segs  = d1_side[SEGW-1:0];
        d_v1    = d1_side[SEGW];
        d_v2    = d2_side;
        one1    = d_v1 & ~d_v2;
        one2    = d_v2 & ~d_v1;
        gen     = ~d_v1 & ~d_v2;
        ksel    = one1 ? k2 : k1;
        x2a_ext = DXW'(d_segs.seg2_start_x);
        priority if (one1)
        begin
            tsel    = DXW'(d_segs.seg1_start_x) - DXW'(d_segs.seg2_end_x);
            yb_next = d_segs.seg2_end_y;
        end
        else if (one2)
        begin
            tsel    = DXW'(d_segs.seg2_start_x) - DXW'(d_segs.seg1_end_x);
            yb_next = d_segs.seg1_end_y;
        end
        else
        begin
            tsel    = DXW'(d_segs.seg1_start_x);
            yb_next = d_segs.seg1_end_y;
        end
        priority if (d_v1 & d_v2)
        begin
            sat3_next = 1'b0;
        end
        else if (one1)
        begin
            sat3_next = ksat2;
        end
        else if (one2)
        begin
            sat3_next = ksat1;
        end
        else
        begin
            sat3_next = ksat1 | ksat2;
        end
    end

    logic                      s3_valid_reg;
    sct_pkg::seg_pair_t        s3_segs_reg;
    logic signed [W-1:0]       s3_k1_reg;
    logic                      s3_one1_reg, s3_one2_reg, s3_gen_reg, s3_sat_reg;
    logic signed [CW-1:0]      s3_yb_reg;
    logic signed [W-H+DXW-1:0] s3_pa_hi_reg, s3_pb_hi_reg;
    logic signed [H+DXW:0]     s3_pa_lo_reg, s3_pb_lo_reg;
    logic signed [W:0]         s3_dk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= d1_valid & d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_segs_reg  <= d_segs;
        s3_k1_reg    <= k1;
        s3_one1_reg  <= one1;
        s3_one2_reg  <= one2;
        s3_gen_reg   <= gen;
        s3_sat_reg   <= sat3_next;
        s3_yb_reg    <= yb_next;
        s3_pa_hi_reg <= $signed(ksel[W-1:H]) * tsel;
        s3_pa_lo_reg <= $signed({1'b0, ksel[H-1:0]}) * tsel;
        s3_pb_hi_reg <= $signed(k2[W-1:H]) * x2a_ext;
        s3_pb_lo_reg <= $signed({1'b0, k2[H-1:0]}) * x2a_ext;
        s3_dk_reg    <= (W+1)'(k1) - (W+1)'(k2);
    end

    // stage 4: sum partial products, drop fraction (floor), slope difference magnitude
    logic signed [MA_W-1:0] pa_full, pb_full;
    logic signed [W:0]      dk_neg_val;

    always_comb
    begin
        pa_full    = (MA_W'(s3_pa_hi_reg) <<< H) + MA_W'(s3_pa_lo_reg);
        pb_full    = (MA_W'(s3_pb_hi_reg) <<< H) + MA_W'(s3_pb_lo_reg);
        dk_neg_val = -s3_dk_reg;
    end

    logic                    s4_valid_reg;
    sct_pkg::seg_pair_t      s4_segs_reg;
    logic signed [W-1:0]     s4_k1_reg;
    logic                    s4_one1_reg, s4_one2_reg, s4_gen_reg, s4_sat_reg;
    logic signed [CW-1:0]    s4_yb_reg;
    logic signed [SH_W-1:0]  s4_pa_sh_reg, s4_pb_sh_reg;
    logic [W-1:0]            s4_adk_reg;
    logic                    s4_dkneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_segs_reg  <= s3_segs_reg;
        s4_k1_reg    <= s3_k1_reg;
        s4_one1_reg  <= s3_one1_reg;
        s4_one2_reg  <= s3_one2_reg;
        s4_gen_reg   <= s3_gen_reg;
        s4_sat_reg   <= s3_sat_reg;
        s4_yb_reg    <= s3_yb_reg;
        s4_pa_sh_reg <= $signed(pa_full[MA_W-1:F]);
        s4_pb_sh_reg <= $signed(pb_full[MA_W-1:F]);
        s4_adk_reg   <= s3_dk_reg[W] ? dk_neg_val[W-1:0] : s3_dk_reg[W-1:0];
        s4_dkneg_reg <= s3_dk_reg[W];
    end

    // stage 5: line value at the vertical x, intercepts, parallel test
    logic signed [YV_W-1:0] yv_full;
    logic                   yv_ovf;
    logic signed [W-1:0]    yv_next;
    logic signed [BW-1:0]   b1_next, b2_next;
    logic                   dk_ok_next;

    always_comb
    begin
        yv_full = YV_W'(s4_pa_sh_reg) + YV_W'(s4_yb_reg);
        yv_ovf  = (yv_full[YV_W-1:W-1] != '0) && (yv_full[YV_W-1:W-1] != '1);
        if (yv_ovf)
        begin
            yv_next = yv_full[YV_W-1] ? QMIN : QMAX;
        end
        else
        begin
            yv_next = $signed(yv_full[W-1:0]);
        end
        b1_next    = BW'(s4_pa_sh_reg) - BW'(s4_segs_reg.seg1_start_y);
        b2_next    = BW'(s4_pb_sh_reg) - BW'(s4_segs_reg.seg2_start_y);
        dk_ok_next = s4_gen_reg && (s4_adk_reg != '0) && (s4_adk_reg >= W'(tol_reg));
    end

    logic                  s5_valid_reg;
    sct_pkg::seg_pair_t    s5_segs_reg;
    logic signed [W-1:0]   s5_k1_reg;
    logic                  s5_one1_reg, s5_one2_reg, s5_sat_reg;
    logic signed [W-1:0]   s5_yv_reg;
    logic                  s5_yvsat_reg;
    logic signed [BW-1:0]  s5_b1_reg, s5_b2_reg;
    logic                  s5_dk_ok_reg;
    logic [W-1:0]          s5_adk_reg;
    logic                  s5_dkneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_segs_reg  <= s4_segs_reg;
        s5_k1_reg    <= s4_k1_reg;
        s5_one1_reg  <= s4_one1_reg;
        s5_one2_reg  <= s4_one2_reg;
        s5_sat_reg   <= s4_sat_reg;
        s5_yv_reg    <= yv_next;
        s5_yvsat_reg <= yv_ovf;
        s5_b1_reg    <= b1_next;
        s5_b2_reg    <= b2_next;
        s5_dk_ok_reg <= dk_ok_next;
        s5_adk_reg   <= s4_adk_reg;
        s5_dkneg_reg <= s4_dkneg_reg;
    end

    // stage 6: intercept difference, one-vertical verdict
    logic hit_v_next;

    always_comb
    begin
        priority if (s5_one1_reg)
        begin
            hit_v_next = strictly_between(s5_yv_reg, W'(s5_segs_reg.seg1_start_y),
                                          W'(s5_segs_reg.seg1_end_y))
                       & strictly_between(W'(s5_segs_reg.seg1_start_x),
                                          W'(s5_segs_reg.seg2_start_x),
                                          W'(s5_segs_reg.seg2_end_x));
        end
        else if (s5_one2_reg)
        begin
            hit_v_next = strictly_between(s5_yv_reg, W'(s5_segs_reg.seg2_start_y),
                                          W'(s5_segs_reg.seg2_end_y))
                       & strictly_between(W'(s5_segs_reg.seg2_start_x),
                                          W'(s5_segs_reg.seg1_start_x),
                                          W'(s5_segs_reg.seg1_end_x));
        end
        else
        begin
            hit_v_next = 1'b0;
        end
    end

    logic                  s6_valid_reg;
    sct_pkg::seg_pair_t    s6_segs_reg;
    logic signed [W-1:0]   s6_k1_reg;
    logic signed [BW-1:0]  s6_b1_reg;
    logic signed [DFW-1:0] s6_diff_reg;
    logic                  s6_hit_v_reg, s6_sat_reg, s6_dk_ok_reg, s6_dkneg_reg;
    logic [W-1:0]          s6_adk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_segs_reg  <= s5_segs_reg;
        s6_k1_reg    <= s5_k1_reg;
        s6_b1_reg    <= s5_b1_reg;
        s6_diff_reg  <= DFW'(s5_b1_reg) - DFW'(s5_b2_reg);
        s6_hit_v_reg <= hit_v_next;
        s6_sat_reg   <= s5_sat_reg | ((s5_one1_reg | s5_one2_reg) & s5_yvsat_reg);
        s6_dk_ok_reg <= s5_dk_ok_reg;
        s6_dkneg_reg <= s5_dkneg_reg;
        s6_adk_reg   <= s5_adk_reg;
    end

    // stage 7: divider operands for the crossing x
    logic signed [DFW-1:0] diff_neg_val;

    assign diff_neg_val = -s6_diff_reg;

    logic              s7_valid_reg;
    logic [NWX-1:0]    s7_num_reg;
    logic [W-1:0]      s7_den_reg;
    logic              s7_neg_reg;
    logic [PWX-1:0]    s7_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_num_reg  <= {(s6_diff_reg[DFW-1] ? diff_neg_val : s6_diff_reg), {F{1'b0}}};
        s7_den_reg  <= s6_adk_reg;
        s7_neg_reg  <= s6_diff_reg[DFW-1] ^ s6_dkneg_reg;
        s7_side_reg <= {s6_k1_reg, s6_b1_reg, s6_segs_reg,
                        s6_dk_ok_reg, s6_hit_v_reg, s6_sat_reg};
    end

    // crossing x divider
    logic                dx_valid;
    logic signed [W-1:0] xq;
    logic                xsat;
    logic [PWX-1:0]      dx_side;

    sct_div #(.NW(NWX), .DW(W), .QB(W), .PW(PWX)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s7_valid_reg),
        .num_mag  (s7_num_reg),
        .den_mag  (s7_den_reg),
        .neg      (s7_neg_reg),
        .side_in  (s7_side_reg),
        .out_valid(dx_valid),
        .quot     (xq),
        .sat      (xsat),
        .side_out (dx_side)
    );

    // stage 8: x range test, partial products of k1 * x
    logic signed [W-1:0]  x_k1;
    logic signed [BW-1:0] x_b1;
    sct_pkg::seg_pair_t   x_segs;
    logic                 x_dk_ok, x_hit_v, x_sat;
    logic                 xin_next;

    always_comb
    begin
        x_k1     = $signed(dx_side[PWX-1 -: W]);
        x_b1     = $signed(dx_side[SEGW+3 +: BW]);
        x_segs   = dx_side[3 +: SEGW];
        x_dk_ok  = dx_side[2];
        x_hit_v  = dx_side[1];
        x_sat    = dx_side[0];
        xin_next = strictly_between(xq, W'(x_segs.seg1_start_x), W'(x_segs.seg1_end_x))
                 & strictly_between(xq, W'(x_segs.seg2_start_x), W'(x_segs.seg2_end_x));
    end

    logic                      s8_valid_reg;
    sct_pkg::seg_pair_t        s8_segs_reg;
    logic signed [BW-1:0]      s8_b1_reg;
    logic signed [2*W-H-1:0]   s8_pf_hi_reg;
    logic signed [H+W:0]       s8_pf_lo_reg;
    logic                      s8_xin_reg, s8_sat_reg, s8_dk_ok_reg, s8_hit_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_valid_reg <= 1'b0;
        end
        else
        begin
            s8_valid_reg <= dx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s8_segs_reg  <= x_segs;
        s8_b1_reg    <= x_b1;
        s8_pf_hi_reg <= $signed(x_k1[W-1:H]) * xq;
        s8_pf_lo_reg <= $signed({1'b0, x_k1[H-1:0]}) * xq;
        s8_xin_reg   <= xin_next;
        s8_sat_reg   <= x_sat | (x_dk_ok & xsat);
        s8_dk_ok_reg <= x_dk_ok;
        s8_hit_v_reg <= x_hit_v;
    end

    // stage 9: sum partial products, drop fraction (floor)
    logic signed [MF_W-1:0] pf_full;

    assign pf_full = (MF_W'(s8_pf_hi_reg) <<< H) + MF_W'(s8_pf_lo_reg);

    logic                   s9_valid_reg;
    sct_pkg::seg_pair_t     s9_segs_reg;
    logic signed [BW-1:0]   s9_b1_reg;
    logic signed [FS_W-1:0] s9_pf_sh_reg;
    logic                   s9_xin_reg, s9_sat_reg, s9_dk_ok_reg, s9_hit_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_valid_reg <= 1'b0;
        end
        else
        begin
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s9_segs_reg  <= s8_segs_reg;
        s9_b1_reg    <= s8_b1_reg;
        s9_pf_sh_reg <= $signed(pf_full[MF_W-1:F]);
        s9_xin_reg   <= s8_xin_reg;
        s9_sat_reg   <= s8_sat_reg;
        s9_dk_ok_reg <= s8_dk_ok_reg;
        s9_hit_v_reg <= s8_hit_v_reg;
    end

    // stage 10: crossing y with saturation
    logic signed [YF_W-1:0] yf_full;
    logic                   yf_ovf;
    logic signed [W-1:0]    yf_next;

    always_comb
    begin
        yf_full = YF_W'(s9_pf_sh_reg) - YF_W'(s9_b1_reg);
        yf_ovf  = (yf_full[YF_W-1:W-1] != '0) && (yf_full[YF_W-1:W-1] != '1);
        if (yf_ovf)
        begin
            yf_next = yf_full[YF_W-1] ? QMIN : QMAX;
        end
        else
        begin
            yf_next = $signed(yf_full[W-1:0]);
        end
    end

    logic                s10_valid_reg;
    sct_pkg::seg_pair_t  s10_segs_reg;
    logic signed [W-1:0] s10_y_reg;
    logic                s10_ysat_reg, s10_xin_reg, s10_sat_reg;
    logic                s10_dk_ok_reg, s10_hit_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_valid_reg <= 1'b0;
        end
        else
        begin
            s10_valid_reg <= s9_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s10_segs_reg  <= s9_segs_reg;
        s10_y_reg     <= yf_next;
        s10_ysat_reg  <= yf_ovf;
        s10_xin_reg   <= s9_xin_reg;
        s10_sat_reg   <= s9_sat_reg;
        s10_dk_ok_reg <= s9_dk_ok_reg;
        s10_hit_v_reg <= s9_hit_v_reg;
    end

    // stage 11: y range test and result register
    logic                   yin;
    sct_pkg::cross_result_t result_next;
    logic                   done_reg;
    sct_pkg::cross_result_t result_reg;

    always_comb
    begin
        yin = strictly_between(s10_y_reg, W'(s10_segs_reg.seg1_start_y),
                               W'(s10_segs_reg.seg1_end_y))
            & strictly_between(s10_y_reg, W'(s10_segs_reg.seg2_start_y),
                               W'(s10_segs_reg.seg2_end_y));
        result_next.crosses   = s10_dk_ok_reg ? (s10_xin_reg & yin) : s10_hit_v_reg;
        result_next.saturated = s10_sat_reg | (s10_dk_ok_reg & s10_ysat_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s10_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
